@@ rtl/point_cloud_fov_range_filter_assert.svh @@
// assertion macros for the point cloud fov/range filter
// expects clk and arst_n in the scope where a macro is used
`ifndef POINT_CLOUD_FOV_RANGE_FILTER_ASSERT_SVH
`define POINT_CLOUD_FOV_RANGE_FILTER_ASSERT_SVH
`ifndef SYNTH
// property checked outside reset
`define PCFR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// property checked also while reset is held
`define PCFR_ASSERT_NR(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCFR_ASSERT(label, prop, msg)
`define PCFR_ASSERT_NR(label, prop, msg)
`endif
`endif

@@ rtl/pcfr_pkg.sv @@
// shared constants, types and helpers of the point cloud fov/range filter
// no dependencies
`default_nettype none

package pcfr_pkg;

	// field and format widths
	localparam int COORD_BITS     = 24;
	localparam int ROT_FRAC_BITS  = 14;
	localparam int ROT_ENTRY_BITS = 16;
	localparam int ROW_BITS       = 3 * ROT_ENTRY_BITS;
	localparam int TAN_BITS       = 24;
	localparam int TAN_FRAC_BITS  = 16;
	localparam int RANGE_BITS     = 23;

	// datapath widths
	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int PROD_W  = DIFF_W + ROT_ENTRY_BITS;
	// sum of three products stays below 2^(COORD_BITS + ROT_ENTRY_BITS + 1)
	localparam int BODY_W  = COORD_BITS + ROT_ENTRY_BITS + 2;
	localparam int MAG_W   = BODY_W - 1;
	localparam int LO_W    = (MAG_W + 1) / 2;
	localparam int HI_W    = MAG_W - LO_W;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int R2_W    = SQ_W + 2;
	localparam int RSQ_W   = 2 * RANGE_BITS;
	localparam int LIM2_W  = RSQ_W + 2 * ROT_FRAC_BITS;
	localparam int CMP_W   = (R2_W > LIM2_W) ? R2_W : LIM2_W;
	localparam int TPL_W   = LO_W + TAN_BITS;
	localparam int TPH_W   = HI_W + TAN_BITS;
	// tangent fraction is never wider than the tangent itself
	localparam int ANG_W   = MAG_W + TAN_BITS;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = ROW_BITS;

	localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW_X    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW_Y    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW_Z    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z     = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_TAN_HALF_FOV = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE    = CFG_IDX_W'(7);

	// reset values: identity rotation, 45 degree half angle, 50 m range
	localparam logic [ROW_BITS-1:0]   ROT_ROW_X_RST = 48'h0000_0000_4000;
	localparam logic [ROW_BITS-1:0]   ROT_ROW_Y_RST = 48'h0000_4000_0000;
	localparam logic [ROW_BITS-1:0]   ROT_ROW_Z_RST = 48'h4000_0000_0000;
	localparam logic [TAN_BITS-1:0]   TAN_RST       = TAN_BITS'(1) << TAN_FRAC_BITS;
	localparam logic [RANGE_BITS-1:0] RANGE_RST     = RANGE_BITS'(50000);
	localparam logic [TAN_BITS-1:0]   TAN_OPEN      = '1;

	typedef logic signed [ROT_ENTRY_BITS-1:0] coef_t;

	typedef struct packed {
		logic [ROW_BITS-1:0]          rot_row_x;
		logic [ROW_BITS-1:0]          rot_row_y;
		logic [ROW_BITS-1:0]          rot_row_z;
		logic signed [COORD_BITS-1:0] origin_x;
		logic signed [COORD_BITS-1:0] origin_y;
		logic signed [COORD_BITS-1:0] origin_z;
		logic [TAN_BITS-1:0]          tan_half_fov;
		logic [RANGE_BITS-1:0]        max_range;
	} cfg_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
		logic                         last;
	} point_t;

	typedef struct packed {
		point_t                   pt;
		logic signed [BODY_W-1:0] bx;
		logic signed [BODY_W-1:0] by;
		logic signed [BODY_W-1:0] bz;
	} body_t;

	// coefficient k of a packed rotation row
	function automatic coef_t row_coef(input logic [ROW_BITS-1:0] row, input int unsigned k);
		return coef_t'(row[k*ROT_ENTRY_BITS +: ROT_ENTRY_BITS]);
	endfunction

	// magnitude of a body coordinate, never reaches 2^MAG_W
	function automatic logic [MAG_W-1:0] body_mag(input logic signed [BODY_W-1:0] v);
		logic signed [BODY_W-1:0] n;
		n = v[BODY_W-1] ? -v : v;
		return n[MAG_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/pcfr_cfg.sv @@
// configuration registers and the squared range limit
// depends on pcfr_pkg
`default_nettype none

module pcfr_cfg import pcfr_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg,
	output logic [RSQ_W-1:0]           range_sq
);

	logic [ROW_BITS-1:0]          rot_row_x_q, rot_row_y_q, rot_row_z_q;
	logic signed [COORD_BITS-1:0] origin_x_q, origin_y_q, origin_z_q;
	logic [TAN_BITS-1:0]          tan_q;
	logic [RANGE_BITS-1:0]        range_q;
	logic [RSQ_W-1:0]             range_sq_q;

	// writes are always taken
	assign cfg_ready = 1'b1;

	// register file, excess data bits dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_row_x_q <= ROT_ROW_X_RST;
			rot_row_y_q <= ROT_ROW_Y_RST;
			rot_row_z_q <= ROT_ROW_Z_RST;
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			origin_z_q  <= '0;
			tan_q       <= TAN_RST;
			range_q     <= RANGE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROT_ROW_X:    rot_row_x_q <= cfg_data[ROW_BITS-1:0];
				REG_ROT_ROW_Y:    rot_row_y_q <= cfg_data[ROW_BITS-1:0];
				REG_ROT_ROW_Z:    rot_row_z_q <= cfg_data[ROW_BITS-1:0];
				REG_ORIGIN_X:     origin_x_q  <= cfg_data[COORD_BITS-1:0];
				REG_ORIGIN_Y:     origin_y_q  <= cfg_data[COORD_BITS-1:0];
				REG_ORIGIN_Z:     origin_z_q  <= cfg_data[COORD_BITS-1:0];
				REG_TAN_HALF_FOV: tan_q       <= cfg_data[TAN_BITS-1:0];
				REG_MAX_RANGE:    range_q     <= cfg_data[RANGE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// squared range limit, registered from the range register in the next cycle
	always_ff @(posedge clk) begin
		range_sq_q <= RSQ_W'(range_q) * RSQ_W'(range_q);
	end

	assign cfg.rot_row_x    = rot_row_x_q;
	assign cfg.rot_row_y    = rot_row_y_q;
	assign cfg.rot_row_z    = rot_row_z_q;
	assign cfg.origin_x     = origin_x_q;
	assign cfg.origin_y     = origin_y_q;
	assign cfg.origin_z     = origin_z_q;
	assign cfg.tan_half_fov = tan_q;
	assign cfg.max_range    = range_q;
	assign range_sq         = range_sq_q;

endmodule

`default_nettype wire

@@ rtl/pcfr_xform.sv @@
// stages 1 to 3: origin subtract, matrix products, row sums
// depends on pcfr_pkg and the assertion macro header
`default_nettype none
`include "point_cloud_fov_range_filter_assert.svh"

module pcfr_xform import pcfr_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	input  wire logic   up_valid,
	output logic        up_stall,
	input  wire point_t up_pt,
	output logic        dn_valid,
	input  wire logic   dn_stall,
	output body_t       dn_body
);

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;

	point_t pt_s1, pt_s2, pt_s3;
	logic signed [DIFF_W-1:0] d_s1 [3];
	logic signed [PROD_W-1:0] prod_s2 [3][3];
	logic signed [BODY_W-1:0] body_s3 [3];

	logic signed [COORD_BITS-1:0] pin [3];
	logic signed [COORD_BITS-1:0] org [3];
	logic [ROW_BITS-1:0]          rows [3];
	logic signed [DIFF_W-1:0]     d_c [3];
	logic signed [PROD_W-1:0]     prod_c [3][3];
	logic signed [BODY_W-1:0]     body_c [3];

	// stage advance: a stage loads when empty or when its successor moves
	assign en_s3    = !v_s3 || !dn_stall;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign up_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= up_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	assign pin[0]  = up_pt.x;
	assign pin[1]  = up_pt.y;
	assign pin[2]  = up_pt.z;
	assign org[0]  = cfg.origin_x;
	assign org[1]  = cfg.origin_y;
	assign org[2]  = cfg.origin_z;
	assign rows[0] = cfg.rot_row_x;
	assign rows[1] = cfg.rot_row_y;
	assign rows[2] = cfg.rot_row_z;

	// offset from the sensor origin, exact in one extra bit
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d_c[k] = DIFF_W'(pin[k]) - DIFF_W'(org[k]);
		end
	end

	// nine coefficient products
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			for (int k = 0; k < 3; k++) begin
				prod_c[j][k] = PROD_W'(d_s1[k]) * PROD_W'(row_coef(rows[j], k));
			end
		end
	end

	// row sums give body coordinates in 2^-ROT_FRAC_BITS mm
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			body_c[j] = BODY_W'(prod_s2[j][0]) + BODY_W'(prod_s2[j][1])
				+ BODY_W'(prod_s2[j][2]);
		end
	end

	// stage data registers
	always_ff @(posedge clk) begin
		if (en_s1) begin
			pt_s1 <= up_pt;
			d_s1  <= d_c;
		end
		if (en_s2) begin
			pt_s2   <= pt_s1;
			prod_s2 <= prod_c;
		end
		if (en_s3) begin
			pt_s3   <= pt_s2;
			body_s3 <= body_c;
		end
	end

	assign dn_valid   = v_s3;
	assign dn_body.pt = pt_s3;
	assign dn_body.bx = body_s3[0];
	assign dn_body.by = body_s3[1];
	assign dn_body.bz = body_s3[2];

	`PCFR_ASSERT(a_s1_hold, v_s1 && !en_s2 |=> v_s1, "stalled stage 1 request lost")
	`PCFR_ASSERT(a_s3_fill, v_s2 && !v_s3 |=> v_s3, "empty stage 3 did not take request")

endmodule

`default_nettype wire

@@ rtl/pcfr_test.sv @@
// stages 4 to 6: magnitudes and partial products, fov test, range test
// depends on pcfr_pkg and the assertion macro header
`default_nettype none
`include "point_cloud_fov_range_filter_assert.svh"

module pcfr_test import pcfr_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire logic [RSQ_W-1:0] range_sq,
	input  wire logic             up_valid,
	output logic                  up_stall,
	input  wire body_t            up_body,
	output logic                  dn_valid,
	input  wire logic             dn_stall,
	output point_t                dn_pt,
	output logic                  dn_keep
);

	logic v_s4, v_s5, v_s6;
	logic en_s4, en_s5, en_s6;

	point_t pt_s4, pt_s5, pt_s6;
	logic   x_ok_s4, x_ok_s5;
	logic   tan_open_s4;
	logic   ang_ok_s5;
	logic   keep_s6;
	logic [MAG_W-1:0]     ay_s4;
	logic [TPL_W-1:0]     tp_lo_s4;
	logic [TPH_W-1:0]     tp_hi_s4;
	logic [2*LO_W-1:0]    sq_ll_s4 [3];
	logic [LO_W+HI_W-1:0] sq_lh_s4 [3];
	logic [2*HI_W-1:0]    sq_hh_s4 [3];
	logic [SQ_W-1:0]      sq_s5 [3];

	logic signed [BODY_W-1:0] b [3];
	logic [MAG_W-1:0]         a_c [3];
	logic                     x_ok_c;
	logic [TPL_W-1:0]         tp_lo_c;
	logic [TPH_W-1:0]         tp_hi_c;
	logic [2*LO_W-1:0]        sq_ll_c [3];
	logic [LO_W+HI_W-1:0]     sq_lh_c [3];
	logic [2*HI_W-1:0]        sq_hh_c [3];
	logic [SQ_W-1:0]          sq_c [3];
	logic [ANG_W-1:0]         ang_lhs, ang_rhs;
	logic                     ang_ok_c;
	logic [CMP_W-1:0]         r2_c, lim2_c;
	logic                     keep_c;

	// stage advance
	assign en_s6    = !v_s6 || !dn_stall;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign up_stall = !en_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s4) v_s4 <= up_valid;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	assign b[0] = up_body.bx;
	assign b[1] = up_body.by;
	assign b[2] = up_body.bz;

	// body x must be positive and at least one millimetre
	assign x_ok_c = !b[0][BODY_W-1]
		&& (b[0][BODY_W-2:0] >= ((BODY_W-1)'(1) << ROT_FRAC_BITS));

	// magnitudes split in halves for the narrow multipliers
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			a_c[j]     = body_mag(b[j]);
			sq_ll_c[j] = (2*LO_W)'(a_c[j][LO_W-1:0]) * (2*LO_W)'(a_c[j][LO_W-1:0]);
			sq_lh_c[j] = (LO_W+HI_W)'(a_c[j][LO_W-1:0])
				* (LO_W+HI_W)'(a_c[j][MAG_W-1:LO_W]);
			sq_hh_c[j] = (2*HI_W)'(a_c[j][MAG_W-1:LO_W])
				* (2*HI_W)'(a_c[j][MAG_W-1:LO_W]);
		end
	end

	// body x times tangent, in two halves
	assign tp_lo_c = TPL_W'(a_c[0][LO_W-1:0]) * TPL_W'(cfg.tan_half_fov);
	assign tp_hi_c = TPH_W'(a_c[0][MAG_W-1:LO_W]) * TPH_W'(cfg.tan_half_fov);

	// fov test: |y| * 2^TAN_FRAC_BITS <= x * tan, widest tangent passes all
	assign ang_lhs  = ANG_W'(ay_s4) << TAN_FRAC_BITS;
	assign ang_rhs  = (ANG_W'(tp_hi_s4) << LO_W) + ANG_W'(tp_lo_s4);
	assign ang_ok_c = tan_open_s4 || (ang_lhs <= ang_rhs);

	// assemble the three squares
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			sq_c[j] = (SQ_W'(sq_hh_s4[j]) << (2*LO_W)) + (SQ_W'(sq_lh_s4[j]) << (LO_W+1))
				+ SQ_W'(sq_ll_s4[j]);
		end
	end

	// range test against max_range^2 in the same fixed-point scale
	assign r2_c   = CMP_W'(sq_s5[0]) + CMP_W'(sq_s5[1]) + CMP_W'(sq_s5[2]);
	assign lim2_c = CMP_W'(range_sq) << (2*ROT_FRAC_BITS);
	assign keep_c = x_ok_s5 && ang_ok_s5 && (r2_c <= lim2_c);

	// stage data registers
	always_ff @(posedge clk) begin
		if (en_s4) begin
			pt_s4       <= up_body.pt;
			x_ok_s4     <= x_ok_c;
			tan_open_s4 <= (cfg.tan_half_fov == TAN_OPEN);
			ay_s4       <= a_c[1];
			tp_lo_s4    <= tp_lo_c;
			tp_hi_s4    <= tp_hi_c;
			sq_ll_s4    <= sq_ll_c;
			sq_lh_s4    <= sq_lh_c;
			sq_hh_s4    <= sq_hh_c;
		end
		if (en_s5) begin
			pt_s5     <= pt_s4;
			x_ok_s5   <= x_ok_s4;
			ang_ok_s5 <= ang_ok_c;
			sq_s5     <= sq_c;
		end
		if (en_s6) begin
			pt_s6   <= pt_s5;
			keep_s6 <= keep_c;
		end
	end

	assign dn_valid = v_s6;
	assign dn_pt    = pt_s6;
	assign dn_keep  = keep_s6;

	`PCFR_ASSERT(a_keep_needs_tests, v_s5 && en_s6 && !(x_ok_s5 && ang_ok_s5) |=> !keep_s6, "kept point failed x or fov test")
	`PCFR_ASSERT(a_empty_out_moves, !v_s6 |-> en_s4, "pipe held back with empty output stage")
	`PCFR_ASSERT_NR(a_rst_empty, !arst_n |=> !v_s4 && !v_s5 && !v_s6, "stage valid set during reset")

endmodule

`default_nettype wire

@@ rtl/point_cloud_fov_range_filter.sv @@
// top level of the point cloud fov/range filter
// depends on pcfr_pkg, pcfr_cfg, pcfr_xform, pcfr_test
`default_nettype none

// Takes one world-frame point per cycle unless stalled and returns it unchanged with
// a keep flag and the end-of-cloud mark. Body coordinates come from (point - origin)
// times the world-to-body rows (Q2.14); keep is set when body x >= 1 mm,
// |y| <= x * tan_half_fov (all ones opens the angle fully) and x^2 + y^2 + z^2 <=
// max_range^2, all exact. Throughput is one point per clock when nothing stalls, in
// the six-stage pipeline (subtract, products, row sums, magnitudes and partial
// products, fov test and square assembly, range test into the output register). Stall
// on the result side backs up stage by stage, so bubbles are squeezed out and the
// input keeps taking points while a result waits until all six stages are full.
// Configuration writes are taken every cycle; write only while no point is in flight,
// since settings are read at several stages. No clearing pass.

module point_cloud_fov_range_filter import pcfr_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [CFG_DATA_W-1:0]        cfg_data,
	input  wire logic                         point_valid,
	output logic                              point_stall,
	input  wire logic signed [COORD_BITS-1:0] point_x,
	input  wire logic signed [COORD_BITS-1:0] point_y,
	input  wire logic signed [COORD_BITS-1:0] point_z,
	input  wire logic                         last_point,
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output logic signed [COORD_BITS-1:0]      out_x,
	output logic signed [COORD_BITS-1:0]      out_y,
	output logic signed [COORD_BITS-1:0]      out_z,
	output logic                              keep,
	output logic                              end_of_cloud
);

	cfg_t             cfg;
	logic [RSQ_W-1:0] range_sq;
	point_t           in_pt;
	point_t           res_pt;
	body_t            body;
	logic             body_valid, body_stall;

	assign in_pt.x    = point_x;
	assign in_pt.y    = point_y;
	assign in_pt.z    = point_z;
	assign in_pt.last = last_point;

	// configuration registers
	pcfr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.range_sq  (range_sq)
	);

	// transform into the body frame
	pcfr_xform u_xform (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.up_valid (point_valid),
		.up_stall (point_stall),
		.up_pt    (in_pt),
		.dn_valid (body_valid),
		.dn_stall (body_stall),
		.dn_body  (body)
	);

	// fov and range tests
	pcfr_test u_test (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.range_sq (range_sq),
		.up_valid (body_valid),
		.up_stall (body_stall),
		.up_body  (body),
		.dn_valid (result_valid),
		.dn_stall (result_stall),
		.dn_pt    (res_pt),
		.dn_keep  (keep)
	);

	assign out_x        = res_pt.x;
	assign out_y        = res_pt.y;
	assign out_z        = res_pt.z;
	assign end_of_cloud = res_pt.last;

endmodule

`default_nettype wire
